// ===== src/dpes_pkg.sv =====
// ----------------------------------------------------------------------------
// dpes_pkg
// Shared types and codes of the degree-preserving edge swap engine.
// ----------------------------------------------------------------------------
package dpes_pkg;

	// item commands
	localparam logic [1:0] CMD_LOAD_EDGE = 2'd0;
	localparam logic [1:0] CMD_LOAD_EXCL = 2'd1;
	localparam logic [1:0] CMD_SWAP      = 2'd2;
	localparam logic [1:0] CMD_READ      = 2'd3;

	// outcome codes
	localparam logic [2:0] OUT_SWAPPED  = 3'd0;
	localparam logic [2:0] OUT_SAME     = 3'd1;
	localparam logic [2:0] OUT_SELFLOOP = 3'd2;
	localparam logic [2:0] OUT_DUP      = 3'd3;
	localparam logic [2:0] OUT_REVDUP   = 3'd4;
	localparam logic [2:0] OUT_EXCL     = 3'd5;
	localparam logic [2:0] OUT_DONE     = 3'd6;

	// register indexes
	localparam logic [1:0] REG_DIRECTED = 2'd0;
	localparam logic [1:0] REG_EDGE_CNT = 2'd1;
	localparam logic [1:0] REG_EXCL_CNT = 2'd2;

	// edge memory write modes
	localparam logic [1:0] EW_NONE = 2'd0;
	localparam logic [1:0] EW_LOAD = 2'd1;
	localparam logic [1:0] EW_A    = 2'd2;
	localparam logic [1:0] EW_B    = 2'd3;

	// set memory write modes
	localparam logic [1:0] SW_NONE  = 2'd0;
	localparam logic [1:0] SW_MOVE  = 2'd1;
	localparam logic [1:0] SW_CLEAR = 2'd2;
	localparam logic [1:0] SW_ADD   = 2'd3;

	// key selects: (source, target) pair fed to the set logic
	localparam logic [2:0] KS_ST   = 3'd0;
	localparam logic [2:0] KS_OLD  = 3'd1;
	localparam logic [2:0] KS_SATB = 3'd2;
	localparam logic [2:0] KS_TBSA = 3'd3;
	localparam logic [2:0] KS_SBTA = 3'd4;
	localparam logic [2:0] KS_TASB = 3'd5;
	localparam logic [2:0] KS_SBTB = 3'd6;

	// hash multiplier
	localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

	typedef struct packed {
		logic       directed;
		logic [12:0] edge_cnt;
		logic [6:0]  excl_cnt;
	} dpes_cfg_t;

	typedef struct packed {
		logic       ld_item;
		logic       clr_wr;
		logic       e_rd_b;
		logic [1:0] e_wr;
		logic       cap_a;
		logic       cap_b;
		logic       x_wr;
		logic       key_ld;
		logic [2:0] key_sel;
		logic       hash_go;
		logic       hash_ent;
		logic       probe_init;
		logic       probe_next;
		logic       n_one;
		logic       idx_from_j;
		logic [1:0] s_wr;
		logic       x_init;
		logic       x_next;
		logic       out_ld;
		logic [2:0] out_code;
		logic       out_rd;
	} dpes_cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic       hash_done;
		logic [1:0] cmd;
		logic       a_eq_b;
		logic       a_in_edges;
		logic       a_in_excl;
		logic       ab_in_count;
		logic       written_a;
		logic       directed;
		logic       self_eq;
		logic       ent_used;
		logic       ent_match;
		logic       n_last;
		logic       n_full;
		logic       move;
		logic       x_end;
		logic       x_hit;
	} dpes_stat_t;

endpackage

// ===== src/dpes_hash.sv =====
// ----------------------------------------------------------------------------
// dpes_hash
// Multi-cycle home-slot hash: 64-bit multiply in 16-bit chunks, xor-fold,
// then the low bits select the slot (the set size is a power of two).
// ----------------------------------------------------------------------------
module dpes_hash import dpes_pkg::*; #(
	parameter int KW        = 32,
	parameter int SET_SLOTS = 8192,
	localparam int SW       = $clog2(SET_SLOTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [KW-1:0] key,
	output logic          done,
	output logic [SW-1:0] home
);

	localparam int NCH = (KW + 15) / 16;
	localparam int PW  = 16 * NCH;

	localparam logic [1:0] H_IDLE = 2'd0;
	localparam logic [1:0] H_MUL  = 2'd1;
	localparam logic [1:0] H_XOR  = 2'd2;

	logic [1:0]    ph_q;
	logic [6:0]    cnt_q;
	logic [PW-1:0] kk_q;
	logic [63:0]   m_q;
	logic [63:0]   acc_q;
	logic          done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= H_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				H_IDLE: begin
					cnt_q <= '0;
					if (go) ph_q <= H_MUL;
				end
				H_MUL: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(NCH - 1)) ph_q <= H_XOR;
				end
				H_XOR: begin
					cnt_q  <= '0;
					ph_q   <= H_IDLE;
					done_q <= 1'b1;
				end
				default: ph_q <= H_IDLE;
			endcase
		end
	end

	// datapath; the result holds until the next start
	always_ff @(posedge clk) begin
		case (ph_q)
			H_IDLE: begin
				if (go) begin
					kk_q  <= PW'(key);
					m_q   <= HASH_MUL;
					acc_q <= '0;
				end
			end
			H_MUL: begin
				acc_q <= acc_q + 64'(kk_q[15:0] * m_q);
				m_q   <= m_q << 16;
				kk_q  <= kk_q >> 16;
			end
			H_XOR: begin
				acc_q <= acc_q ^ (acc_q >> 29);
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign home = acc_q[SW-1:0];

endmodule

// ===== src/dpes_datapath.sv =====
// ----------------------------------------------------------------------------
// dpes_datapath
// Edge, excluded and presence memories, item registers, probe pointers and
// the result register.
// ----------------------------------------------------------------------------
module dpes_datapath import dpes_pkg::*; #(
	parameter int MAX_EDGES    = 4096,
	parameter int MAX_EXCLUDED = 64,
	parameter int NODE_BITS    = 16,
	parameter int SET_SLOTS    = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dpes_cmd_t   ctl,
	output dpes_stat_t  st,
	input  dpes_cfg_t   cfg,
	input  logic [1:0]  cmd,
	input  logic [11:0] slot_a,
	input  logic [11:0] slot_b,
	input  logic [15:0] source_node,
	input  logic [15:0] target_node,
	output logic        done,
	output logic [2:0]  outcome,
	output logic [15:0] read_source,
	output logic [15:0] read_target
);

	localparam int NB    = NODE_BITS;
	localparam int KW    = 2 * NB;
	localparam int EA    = $clog2(MAX_EDGES);
	localparam int XA    = (MAX_EXCLUDED > 1) ? $clog2(MAX_EXCLUDED) : 1;
	localparam int XW    = $clog2(MAX_EXCLUDED + 1);
	localparam int SW    = $clog2(SET_SLOTS);
	localparam int NW    = $clog2(SET_SLOTS + 1);
	localparam int CLR_N = (MAX_EDGES > SET_SLOTS) ? MAX_EDGES : SET_SLOTS;
	localparam int CW    = $clog2(CLR_N);

	// item registers
	logic [1:0]    cmd_q;
	logic [11:0]   a_q, b_q;
	logic [NB-1:0] s_q, t_q;
	logic [NB-1:0] sa_q, ta_q, sb_q, tb_q;
	logic          wa_q;
	logic [NB-1:0] ks_q, kt_q;
	logic [SW-1:0] idx_q, jdx_q;
	logic [NW-1:0] n_q;
	logic [XW-1:0] ex_q;
	logic [CW-1:0] clr_q;

	// memories and read registers
	logic [2*NB:0]   em [MAX_EDGES];
	logic [KW-1:0]   xm [MAX_EXCLUDED];
	logic [KW:0]     sm [SET_SLOTS];
	logic [2*NB:0]   er_q;
	logic [KW-1:0]   xr_q;
	logic [KW:0]     sr_q;

	// result
	logic          done_q;
	logic [2:0]    outcome_q;
	logic [15:0]   rs_q, rt_q;

	logic [NB-1:0] ks_d, kt_d;
	logic [KW-1:0] hkey;
	logic          hdone;
	logic [SW-1:0] home;
	logic          ewe, xwe, swe;
	logic [EA-1:0] ewa;
	logic [2*NB:0] ewd;
	logic [SW-1:0] swa;
	logic [KW:0]   swd;
	logic [31:0]   eff_n, eff_x;
	logic [SW-1:0] jdx_nx;

	// home slot hash
	assign hkey = ctl.hash_ent ? sr_q[KW-1:0] : {ks_q, kt_q};

	dpes_hash #(.KW(KW), .SET_SLOTS(SET_SLOTS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (ctl.hash_go),
		.key    (hkey),
		.done   (hdone),
		.home   (home)
	);

	// key select
	always_comb begin
		case (ctl.key_sel)
			KS_ST:   begin ks_d = s_q;  kt_d = t_q;  end
			KS_OLD:  begin ks_d = sa_q; kt_d = ta_q; end
			KS_SATB: begin ks_d = sa_q; kt_d = tb_q; end
			KS_TBSA: begin ks_d = tb_q; kt_d = sa_q; end
			KS_SBTA: begin ks_d = sb_q; kt_d = ta_q; end
			KS_TASB: begin ks_d = ta_q; kt_d = sb_q; end
			KS_SBTB: begin ks_d = sb_q; kt_d = tb_q; end
			default: begin ks_d = s_q;  kt_d = t_q;  end
		endcase
	end

	// edge memory write port
	always_comb begin
		ewe = 1'b0;
		ewa = EA'(a_q);
		ewd = {1'b1, s_q, t_q};
		if (ctl.clr_wr) begin
			ewe = 32'(clr_q) < 32'(MAX_EDGES);
			ewa = EA'(clr_q);
			ewd = '0;
		end else begin
			case (ctl.e_wr)
				EW_LOAD: ewe = 1'b1;
				EW_A: begin
					ewe = 1'b1;
					ewd = {1'b1, sa_q, tb_q};
				end
				EW_B: begin
					ewe = 1'b1;
					ewa = EA'(b_q);
					ewd = {1'b1, sb_q, ta_q};
				end
				default: ewe = 1'b0;
			endcase
		end
	end

	// set memory write port
	always_comb begin
		swe = 1'b0;
		swa = idx_q;
		swd = '0;
		if (ctl.clr_wr) begin
			swe = 32'(clr_q) < 32'(SET_SLOTS);
			swa = SW'(clr_q);
		end else begin
			case (ctl.s_wr)
				SW_MOVE: begin
					swe = 1'b1;
					swd = {1'b1, sr_q[KW-1:0]};
				end
				SW_CLEAR: swe = 1'b1;
				SW_ADD: begin
					swe = 1'b1;
					swa = jdx_q;
					swd = {1'b1, ks_q, kt_q};
				end
				default: swe = 1'b0;
			endcase
		end
	end

	assign xwe = ctl.x_wr;

	// memories
	always_ff @(posedge clk) begin
		if (ewe) em[ewa] <= ewd;
		er_q <= em[ctl.e_rd_b ? EA'(b_q) : EA'(a_q)];
	end

	always_ff @(posedge clk) begin
		if (xwe) xm[XA'(a_q)] <= {s_q, t_q};
		xr_q <= xm[XA'(ex_q)];
	end

	always_ff @(posedge clk) begin
		if (swe) sm[swa] <= swd;
		sr_q <= sm[jdx_q];
	end

	// probe pointer wraps at the set size
	assign jdx_nx = (jdx_q == SW'(SET_SLOTS - 1)) ? '0 : jdx_q + SW'(1);

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.ld_item) begin
			cmd_q <= cmd;
			a_q   <= slot_a;
			b_q   <= slot_b;
			s_q   <= NB'(source_node);
			t_q   <= NB'(target_node);
		end
		if (ctl.cap_a) begin
			wa_q <= er_q[2*NB];
			sa_q <= er_q[2*NB-1:NB];
			ta_q <= er_q[NB-1:0];
		end
		if (ctl.cap_b) begin
			sb_q <= er_q[2*NB-1:NB];
			tb_q <= er_q[NB-1:0];
		end
		if (ctl.key_ld) begin
			ks_q <= ks_d;
			kt_q <= kt_d;
		end
		if (ctl.probe_init) jdx_q <= home;
		else if (ctl.probe_next) jdx_q <= jdx_nx;
		if (ctl.idx_from_j) idx_q <= jdx_q;
		if (ctl.probe_init) n_q <= '0;
		else if (ctl.n_one) n_q <= NW'(1);
		else if (ctl.probe_next) n_q <= n_q + NW'(1);
		if (ctl.x_init) ex_q <= '0;
		else if (ctl.x_next) ex_q <= ex_q + XW'(1);
		if (ctl.out_ld) begin
			outcome_q <= ctl.out_code;
			rs_q <= ctl.out_rd ? 16'(er_q[2*NB-1:NB]) : 16'd0;
			rt_q <= ctl.out_rd ? 16'(er_q[NB-1:0]) : 16'd0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (ctl.clr_wr) clr_q <= clr_q + CW'(1);
			done_q <= ctl.out_ld;
		end
	end

	// status
	assign eff_n = (32'(cfg.edge_cnt) < 32'(MAX_EDGES)) ? 32'(cfg.edge_cnt) : 32'(MAX_EDGES);
	assign eff_x = (32'(cfg.excl_cnt) < 32'(MAX_EXCLUDED)) ? 32'(cfg.excl_cnt)
		: 32'(MAX_EXCLUDED);

	always_comb begin
		st.clr_last    = clr_q == CW'(CLR_N - 1);
		st.hash_done   = hdone;
		st.cmd         = cmd_q;
		st.a_eq_b      = a_q == b_q;
		st.a_in_edges  = 32'(a_q) < 32'(MAX_EDGES);
		st.a_in_excl   = 32'(a_q) < 32'(MAX_EXCLUDED);
		st.ab_in_count = (32'(a_q) < eff_n) && (32'(b_q) < eff_n);
		st.written_a   = wa_q;
		st.directed    = cfg.directed;
		st.self_eq     = ks_q == kt_q;
		st.ent_used    = sr_q[KW];
		st.ent_match   = sr_q[KW-1:0] == {ks_q, kt_q};
		st.n_last      = n_q == NW'(SET_SLOTS - 1);
		st.n_full      = n_q == NW'(SET_SLOTS);
		st.move        = (jdx_q > idx_q) ? ((home <= idx_q) || (home > jdx_q))
			: ((home <= idx_q) && (home > jdx_q));
		st.x_end       = 32'(ex_q) >= eff_x;
		st.x_hit       = xr_q == {ks_q, kt_q};
	end

	assign done        = done_q;
	assign outcome     = outcome_q;
	assign read_source = rs_q;
	assign read_target = rt_q;

endmodule

// ===== src/dpes_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpes_ctrl
// Controller: clearing sweep, item decode, and a step program for edge loads
// and swaps that runs set lookups, removals, adds and the excluded-list scan.
// ----------------------------------------------------------------------------
module dpes_ctrl import dpes_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  dpes_stat_t st,
	output dpes_cmd_t  ctl
);

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_DEC   = 5'd2;
	localparam logic [4:0] S_CAPA  = 5'd3;
	localparam logic [4:0] S_CAPB  = 5'd4;
	localparam logic [4:0] S_STEP  = 5'd5;
	localparam logic [4:0] S_SELF  = 5'd6;
	localparam logic [4:0] S_HGO   = 5'd7;
	localparam logic [4:0] S_HWAIT = 5'd8;
	localparam logic [4:0] S_PRD   = 5'd9;
	localparam logic [4:0] S_PCHK  = 5'd10;
	localparam logic [4:0] S_RRD   = 5'd11;
	localparam logic [4:0] S_RCHK  = 5'd12;
	localparam logic [4:0] S_RHW   = 5'd13;
	localparam logic [4:0] S_RMV   = 5'd14;
	localparam logic [4:0] S_RCLR  = 5'd15;
	localparam logic [4:0] S_XINIT = 5'd16;
	localparam logic [4:0] S_XRD   = 5'd17;
	localparam logic [4:0] S_XCHK  = 5'd18;

	// step operations
	localparam logic [3:0] OP_SELF  = 4'd0;
	localparam logic [3:0] OP_FIND3 = 4'd1;
	localparam logic [3:0] OP_FIND4 = 4'd2;
	localparam logic [3:0] OP_EXCL  = 4'd3;
	localparam logic [3:0] OP_REM   = 4'd4;
	localparam logic [3:0] OP_REMW  = 4'd5;
	localparam logic [3:0] OP_WRL   = 4'd6;
	localparam logic [3:0] OP_WRA   = 4'd7;
	localparam logic [3:0] OP_WRB   = 4'd8;
	localparam logic [3:0] OP_ADD   = 4'd9;
	localparam logic [3:0] OP_END   = 4'd10;

	logic [4:0] state_q, state_d;
	logic [3:0] step_q, step_d;
	logic [3:0] op_q, op_d;
	logic       is_load;
	logic [6:0] prog_w;
	logic [3:0] p_op;
	logic [2:0] p_ks;
	logic       found;

	// step programs: {op, key select}
	function automatic logic [6:0] prog(input logic load, input logic [3:0] sn);
		logic [6:0] r;
		r = {OP_END, KS_ST};
		if (load) begin
			case (sn)
				4'd0:    r = {OP_REMW, KS_OLD};
				4'd1:    r = {OP_WRL, KS_ST};
				4'd2:    r = {OP_ADD, KS_ST};
				default: r = {OP_END, KS_ST};
			endcase
		end else begin
			case (sn)
				4'd0:    r = {OP_SELF, KS_SATB};
				4'd1:    r = {OP_FIND3, KS_SATB};
				4'd2:    r = {OP_FIND4, KS_TBSA};
				4'd3:    r = {OP_EXCL, KS_SATB};
				4'd4:    r = {OP_SELF, KS_SBTA};
				4'd5:    r = {OP_FIND3, KS_SBTA};
				4'd6:    r = {OP_FIND4, KS_TASB};
				4'd7:    r = {OP_EXCL, KS_SBTA};
				4'd8:    r = {OP_REM, KS_OLD};
				4'd9:    r = {OP_REM, KS_SBTB};
				4'd10:   r = {OP_WRA, KS_ST};
				4'd11:   r = {OP_WRB, KS_ST};
				4'd12:   r = {OP_ADD, KS_SATB};
				4'd13:   r = {OP_ADD, KS_SBTA};
				default: r = {OP_END, KS_ST};
			endcase
		end
		return r;
	endfunction

	assign is_load = st.cmd == CMD_LOAD_EDGE;
	assign prog_w  = prog(is_load, step_q);
	assign p_op    = prog_w[6:3];
	assign p_ks    = prog_w[2:0];
	assign found   = st.ent_used && st.ent_match;

	// next state and commands
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		op_d    = op_q;
		ctl     = '0;
		case (state_q)
			S_CLR: begin
				ctl.clr_wr = 1'b1;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					ctl.ld_item = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				step_d = '0;
				case (st.cmd)
					CMD_LOAD_EXCL: begin
						ctl.x_wr     = st.a_in_excl;
						ctl.out_ld   = 1'b1;
						ctl.out_code = OUT_DONE;
						state_d      = S_IDLE;
					end
					CMD_SWAP: begin
						if (st.a_eq_b || !st.ab_in_count) begin
							ctl.out_ld   = 1'b1;
							ctl.out_code = OUT_SAME;
							state_d      = S_IDLE;
						end else begin
							state_d = S_CAPA;
						end
					end
					default: begin
						// edge load or read back
						if (st.a_in_edges) begin
							state_d = S_CAPA;
						end else begin
							ctl.out_ld   = 1'b1;
							ctl.out_code = OUT_DONE;
							state_d      = S_IDLE;
						end
					end
				endcase
			end
			S_CAPA: begin
				ctl.cap_a  = 1'b1;
				ctl.e_rd_b = 1'b1;
				case (st.cmd)
					CMD_READ: begin
						ctl.out_ld   = 1'b1;
						ctl.out_rd   = 1'b1;
						ctl.out_code = OUT_DONE;
						state_d      = S_IDLE;
					end
					CMD_SWAP: state_d = S_CAPB;
					default:  state_d = S_STEP;
				endcase
			end
			S_CAPB: begin
				ctl.cap_b = 1'b1;
				state_d   = S_STEP;
			end
			S_STEP: begin
				ctl.key_ld  = 1'b1;
				ctl.key_sel = p_ks;
				op_d        = p_op;
				case (p_op)
					OP_SELF:  state_d = S_SELF;
					OP_FIND3: state_d = S_HGO;
					OP_FIND4: begin
						if (st.directed) step_d = step_q + 4'd1;
						else state_d = S_HGO;
					end
					OP_EXCL:  state_d = S_XINIT;
					OP_REM:   state_d = S_HGO;
					OP_REMW: begin
						if (st.written_a) state_d = S_HGO;
						else step_d = step_q + 4'd1;
					end
					OP_WRL: begin
						ctl.e_wr = EW_LOAD;
						step_d   = step_q + 4'd1;
					end
					OP_WRA: begin
						ctl.e_wr = EW_A;
						step_d   = step_q + 4'd1;
					end
					OP_WRB: begin
						ctl.e_wr = EW_B;
						step_d   = step_q + 4'd1;
					end
					OP_ADD:   state_d = S_HGO;
					default: begin
						ctl.out_ld   = 1'b1;
						ctl.out_code = is_load ? OUT_DONE : OUT_SWAPPED;
						state_d      = S_IDLE;
					end
				endcase
			end
			S_SELF: begin
				if (st.self_eq) begin
					ctl.out_ld   = 1'b1;
					ctl.out_code = OUT_SELFLOOP;
					state_d      = S_IDLE;
				end else begin
					step_d  = step_q + 4'd1;
					state_d = S_STEP;
				end
			end
			S_HGO: begin
				ctl.hash_go = 1'b1;
				state_d     = S_HWAIT;
			end
			S_HWAIT: begin
				if (st.hash_done) begin
					ctl.probe_init = 1'b1;
					state_d        = S_PRD;
				end
			end
			S_PRD: state_d = S_PCHK;
			S_PCHK: begin
				if (!st.ent_used || st.ent_match) begin
					// probe ends: key found or empty slot reached
					case (op_q)
						OP_FIND3: begin
							if (found) begin
								ctl.out_ld   = 1'b1;
								ctl.out_code = OUT_DUP;
								state_d      = S_IDLE;
							end else begin
								step_d  = step_q + 4'd1;
								state_d = S_STEP;
							end
						end
						OP_FIND4: begin
							if (found) begin
								ctl.out_ld   = 1'b1;
								ctl.out_code = OUT_REVDUP;
								state_d      = S_IDLE;
							end else begin
								step_d  = step_q + 4'd1;
								state_d = S_STEP;
							end
						end
						OP_ADD: begin
							if (!found) ctl.s_wr = SW_ADD;
							step_d  = step_q + 4'd1;
							state_d = S_STEP;
						end
						default: begin
							// removal: start the backward shift
							if (found) begin
								ctl.idx_from_j = 1'b1;
								ctl.probe_next = 1'b1;
								ctl.n_one      = 1'b1;
								state_d        = S_RRD;
							end else begin
								step_d  = step_q + 4'd1;
								state_d = S_STEP;
							end
						end
					endcase
				end else if (st.n_last) begin
					// whole table probed, nothing found
					step_d  = step_q + 4'd1;
					state_d = S_STEP;
				end else begin
					ctl.probe_next = 1'b1;
					state_d        = S_PRD;
				end
			end
			S_RRD: state_d = S_RCHK;
			S_RCHK: begin
				if (!st.ent_used) begin
					state_d = S_RCLR;
				end else begin
					ctl.hash_go  = 1'b1;
					ctl.hash_ent = 1'b1;
					state_d      = S_RHW;
				end
			end
			S_RHW: begin
				ctl.hash_ent = 1'b1;
				if (st.hash_done) state_d = S_RMV;
			end
			S_RMV: begin
				if (st.move) begin
					ctl.s_wr       = SW_MOVE;
					ctl.idx_from_j = 1'b1;
				end
				if (st.n_full) begin
					state_d = S_RCLR;
				end else begin
					ctl.probe_next = 1'b1;
					state_d        = S_RRD;
				end
			end
			S_RCLR: begin
				ctl.s_wr = SW_CLEAR;
				step_d   = step_q + 4'd1;
				state_d  = S_STEP;
			end
			S_XINIT: begin
				ctl.x_init = 1'b1;
				state_d    = S_XRD;
			end
			S_XRD: begin
				if (st.x_end) begin
					step_d  = step_q + 4'd1;
					state_d = S_STEP;
				end else begin
					state_d = S_XCHK;
				end
			end
			S_XCHK: begin
				if (st.x_hit) begin
					ctl.out_ld   = 1'b1;
					ctl.out_code = OUT_EXCL;
					state_d      = S_IDLE;
				end else begin
					ctl.x_next = 1'b1;
					state_d    = S_XRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			step_q  <= '0;
			op_q    <= OP_END;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			op_q    <= op_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

// ===== src/degree_preserving_edge_swap_engine.sv =====
// ----------------------------------------------------------------------------
// degree_preserving_edge_swap_engine
// Edge list store with presence set and excluded list; loads, reads back and
// tries target swaps that keep every node's degree.
// ----------------------------------------------------------------------------
// Usage:
//  - An item is taken when start is high and busy is low; cmd selects edge
//    load, excluded-edge load, swap attempt or edge read. One result per item
//    appears on outcome/read_source/read_target with done high for one cycle.
//  - The receiver cannot stall: each result must be taken in its cycle.
//  - Configuration goes over the APB port (0x0 directed_mode, 0x4 edge_count,
//    0x8 excluded_count) while the block is idle, which the user must ensure;
//    the block does not enforce it. pready is always high.
//  - After reset a clearing pass walks the edge and presence memories, one
//    entry a cycle over max(MAX_EDGES, SET_SLOTS) entries; busy stays high.
//  - Each presence-set lookup runs key select, hash start and a multiply/fold
//    hash, then reads and checks probed slots one by one; a removal also
//    rehashes each occupied slot it walks past. A swap that goes through also
//    makes two scans of the excluded entries in use, and takes longer when
//    probes collide. SET_SLOTS is a power of two.
//  - The hash unit and the slot-by-slot probe of the set memory set the rate.
// ----------------------------------------------------------------------------
module degree_preserving_edge_swap_engine import dpes_pkg::*; #(
	parameter int MAX_EDGES    = 4096,
	parameter int MAX_EXCLUDED = 64,
	parameter int NODE_BITS    = 16,
	parameter int SET_SLOTS    = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [11:0] slot_a,
	input  logic [11:0] slot_b,
	input  logic [15:0] source_node,
	input  logic [15:0] target_node,
	output logic        done,
	output logic [2:0]  outcome,
	output logic [15:0] read_source,
	output logic [15:0] read_target
);

	dpes_cfg_t  cfg_q;
	dpes_cmd_t  ctl;
	dpes_stat_t st;
	logic       wr_en;

	// configuration registers
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_DIRECTED: cfg_q.directed <= pwdata[0];
				REG_EDGE_CNT: cfg_q.edge_cnt <= pwdata[12:0];
				REG_EXCL_CNT: cfg_q.excl_cnt <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DIRECTED: prdata = {31'd0, cfg_q.directed};
			REG_EDGE_CNT: prdata = {19'd0, cfg_q.edge_cnt};
			REG_EXCL_CNT: prdata = {25'd0, cfg_q.excl_cnt};
			default:      prdata = '0;
		endcase
	end

	dpes_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.ctl    (ctl)
	);

	dpes_datapath #(
		.MAX_EDGES    (MAX_EDGES),
		.MAX_EXCLUDED (MAX_EXCLUDED),
		.NODE_BITS    (NODE_BITS),
		.SET_SLOTS    (SET_SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.st          (st),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.slot_a      (slot_a),
		.slot_b      (slot_b),
		.source_node (source_node),
		.target_node (target_node),
		.done        (done),
		.outcome     (outcome),
		.read_source (read_source),
		.read_target (read_target)
	);

	// an accepted item always makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// a result only follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in progress");

	// outcome stays within its codes
	a_outcome_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> outcome <= OUT_DONE)
		else $error("outcome code out of range");

	// read data is zero on swap results
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && outcome != OUT_DONE |-> read_source == 16'd0 && read_target == 16'd0)
		else $error("read data on a swap result");

endmodule
